// ===== sv/bpg_pkg.sv =====
`timescale 1ns / 1ps
// package: shared types, constants and glyph palettes of the bmp glyph block
package bpg_pkg;

    // image size bounds, the effective width and height saturate here
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // configuration port
    localparam int CFG_DATA_W = 13;

    typedef enum logic [1:0] {
        REG_DEPTH   = 2'd0,
        REG_WIDTH   = 2'd1,
        REG_HEIGHT  = 2'd2,
        REG_PALETTE = 2'd3
    } cfg_reg_t;

    // depth codes, the codes above MODE_32BPP act as 8bpp
    localparam logic [2:0] MODE_1BPP  = 3'd0;
    localparam logic [2:0] MODE_4BPP  = 3'd1;
    localparam logic [2:0] MODE_8BPP  = 3'd2;
    localparam logic [2:0] MODE_24BPP = 3'd3;
    localparam logic [2:0] MODE_32BPP = 3'd4;

    // fixed glyphs of the 1bpp mode
    localparam logic [7:0] GLYPH_SET   = 8'd32;
    localparam logic [7:0] GLYPH_CLEAR = 8'd219;

    // gradient palettes, first glyph in the top byte
    localparam logic [127:0] PAL_0 = " .:!/rl1Z4H9W8$@";
    localparam logic [63:0]  PAL_1 = " .:^uwUW";
    localparam logic [63:0]  PAL_2 = " .:^raAR";
    localparam logic [31:0]  PAL_3 = {8'd32, 8'd176, 8'd178, 8'd219};

    // reciprocal of 48 in 16 fraction bits, level = sum * RECIP_48 >> 16
    localparam logic [10:0] RECIP_48 = 11'd1366;

    typedef struct packed {
        logic [2:0]  depth_mode;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [2:0]  palette_select;
    } cfg_t;

    typedef struct packed {
        logic [7:0] pixel_byte;
        logic       frame_start;
    } pix_word_t;

    typedef struct packed {
        logic [7:0]  glyph;
        logic [11:0] out_row;
        logic [11:0] out_column;
        logic        last;
        logic        image_done;
    } gly_word_t;

    // one queued job: the pixels that one input byte produces
    typedef struct packed {
        logic        bitmap;
        logic [7:0]  data;
        logic [3:0]  count;
        logic [11:0] column;
        logic [11:0] row;
        logic        done;
    } job_t;

    // map a 4-bit level onto the selected palette, optionally reversed
    function automatic logic [7:0] level_glyph(input logic [3:0] level,
                                               input logic [2:0] sel);
        logic [3:0] idx4;
        logic [2:0] idx3;
        logic [1:0] idx2;
        logic [7:0] g;
        idx4 = level ^ {4{sel[0]}};
        idx3 = level[3:1] ^ {3{sel[0]}};
        idx2 = level[3:2] ^ {2{sel[0]}};
        unique case (sel[2:1])
            2'd0:    g = PAL_0[{~idx4, 3'b000} +: 8];
            2'd1:    g = PAL_1[{~idx3, 3'b000} +: 8];
            2'd2:    g = PAL_2[{~idx3, 3'b000} +: 8];
            default: g = PAL_3[{~idx2, 3'b000} +: 8];
        endcase
        return g;
    endfunction

endpackage

// ===== sv/bpg_front.sv =====
`timescale 1ns / 1ps
// front end: takes bytes, tracks row/column, queues a job per byte with pixels
module bpg_front
    import bpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      pix_valid,
    output logic      pix_stall,
    input  pix_word_t pix_data,
    input  logic      queue_full,
    output logic      job_push,
    output job_t      job
);

    logic [12:0] scan_row_reg, scan_row_next;
    logic [12:0] pixel_column_reg, pixel_column_next;
    logic [14:0] row_byte_count_reg, row_byte_count_next;
    logic [9:0]  channel_sum_reg, channel_sum_next;
    logic [1:0]  channel_index_reg, channel_index_next;
    logic        finished_reg, finished_next;

    logic        accept;
    logic [12:0] width_eff, height_eff;
    logic [2:0]  mode_eff;
    logic [14:0] row_data, stride;

    logic [12:0] sr, pc;
    logic [14:0] rbc;
    logic [9:0]  csum, csum_add;
    logic [1:0]  cidx;
    logic        fin;

    logic [12:0] remain;
    logic [2:0]  cidx_inc, need;
    logic [20:0] rgb_product;
    logic [3:0]  n;
    logic [12:0] pc_after;
    logic [13:0] sr_inc;
    logic [15:0] rbc_inc;
    logic        done;
    logic [12:0] row_diff;

    assign accept    = pix_valid && !queue_full;
    assign pix_stall = queue_full;

    // effective width, height and depth
    always_comb
    begin
        if (cfg.image_width == 13'd0)
            width_eff = 13'd1;
        else if (int'(cfg.image_width) > MAX_WIDTH)
            width_eff = 13'(MAX_WIDTH);
        else
            width_eff = cfg.image_width;

        if (cfg.image_height == 13'd0)
            height_eff = 13'd1;
        else if (int'(cfg.image_height) > MAX_HEIGHT)
            height_eff = 13'(MAX_HEIGHT);
        else
            height_eff = cfg.image_height;

        mode_eff = (cfg.depth_mode > MODE_32BPP) ? MODE_8BPP : cfg.depth_mode;
    end

    // bytes per row and the padded stride
    always_comb
    begin
        unique case (mode_eff)
            MODE_1BPP:  row_data = ({2'b00, width_eff} + 15'd7) >> 3;
            MODE_4BPP:  row_data = ({2'b00, width_eff} + 15'd1) >> 1;
            MODE_24BPP: row_data = {2'b00, width_eff} + {1'b0, width_eff, 1'b0};
            MODE_32BPP: row_data = {width_eff, 2'b00};
            default:    row_data = {2'b00, width_eff};
        endcase
        stride = (row_data + 15'd3) & ~15'd3;
    end

    // counter values seen by this word, cleared on frame start
    always_comb
    begin
        sr   = pix_data.frame_start ? '0 : scan_row_reg;
        pc   = pix_data.frame_start ? '0 : pixel_column_reg;
        rbc  = pix_data.frame_start ? '0 : row_byte_count_reg;
        csum = pix_data.frame_start ? '0 : channel_sum_reg;
        cidx = pix_data.frame_start ? '0 : channel_index_reg;
        fin  = pix_data.frame_start ? 1'b0 : finished_reg;
    end

    // classify the word: pixel count, job payload and next counter values
    always_comb
    begin
        remain      = width_eff - pc;
        cidx_inc    = {1'b0, cidx} + 3'd1;
        need        = (mode_eff == MODE_32BPP) ? 3'd4 : 3'd3;
        csum_add    = (cidx < 2'd3) ? (csum + {2'b00, pix_data.pixel_byte}) : csum;
        rgb_product = csum_add * RECIP_48;

        n                  = 4'd0;
        job.bitmap         = 1'b0;
        job.data           = pix_data.pixel_byte;
        channel_sum_next   = csum;
        channel_index_next = cidx;

        if (pc < width_eff)
        begin
            unique case (mode_eff)
                MODE_1BPP:
                begin
                    n          = (remain >= 13'd8) ? 4'd8 : remain[3:0];
                    job.bitmap = 1'b1;
                end
                MODE_4BPP:
                begin
                    n = (remain == 13'd1) ? 4'd1 : 4'd2;
                end
                MODE_24BPP, MODE_32BPP:
                begin
                    if (cidx_inc >= need)
                    begin
                        n                  = 4'd1;
                        job.data           = {rgb_product[19:16], 4'b0000};
                        channel_sum_next   = '0;
                        channel_index_next = '0;
                    end
                    else
                    begin
                        channel_sum_next   = csum_add;
                        channel_index_next = cidx_inc[1:0];
                    end
                end
                default:
                begin
                    n = 4'd1;
                end
            endcase
        end

        pc_after = pc + {9'd0, n};
        sr_inc   = {1'b0, sr} + 14'd1;
        rbc_inc  = {1'b0, rbc} + 16'd1;
        done     = (n != 4'd0) && (pc_after >= width_eff) && (sr_inc >= {1'b0, height_eff});
        row_diff = height_eff - 13'd1 - sr;

        job.count  = n;
        job.column = pc[11:0];
        job.row    = (sr < height_eff) ? row_diff[11:0] : 12'd0;
        job.done   = done;

        scan_row_next       = sr;
        pixel_column_next   = pc_after;
        row_byte_count_next = rbc;
        finished_next       = done;

        // end of row: padding consumed, step to the next scan row
        if (!done)
        begin
            if (rbc_inc >= {1'b0, stride})
            begin
                row_byte_count_next = '0;
                pixel_column_next   = '0;
                channel_sum_next    = '0;
                channel_index_next  = '0;
                scan_row_next       = sr_inc[12:0];
                finished_next       = (sr_inc >= {1'b0, height_eff});
            end
            else
            begin
                row_byte_count_next = rbc_inc[14:0];
            end
        end

        // image complete: the word is dropped
        if (fin)
        begin
            scan_row_next       = sr;
            pixel_column_next   = pc;
            row_byte_count_next = rbc;
            channel_sum_next    = csum;
            channel_index_next  = cidx;
            finished_next       = fin;
        end

        job_push = accept && !fin && (n != 4'd0);
    end

    // counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_row_reg       <= '0;
            pixel_column_reg   <= '0;
            row_byte_count_reg <= '0;
            channel_sum_reg    <= '0;
            channel_index_reg  <= '0;
            finished_reg       <= 1'b0;
        end
        else if (accept)
        begin
            scan_row_reg       <= scan_row_next;
            pixel_column_reg   <= pixel_column_next;
            row_byte_count_reg <= row_byte_count_next;
            channel_sum_reg    <= channel_sum_next;
            channel_index_reg  <= channel_index_next;
            finished_reg       <= finished_next;
        end
    end

`ifndef ASSERT_OFF
    // no job once the image is complete and no new frame starts
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && finished_reg && !pix_data.frame_start) |-> !job_push)
        else $error("job queued after image completion");

    // a job holds one to eight pixels
    assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> (job.count != 4'd0 && job.count <= 4'd8))
        else $error("job pixel count out of range");
`endif

endmodule

// ===== sv/bpg_queue.sv =====
`timescale 1ns / 1ps
// job queue between the front end and the back end
module bpg_queue
    import bpg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t head,
    output logic empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entries_reg[wr_ptr_reg] <= push_job;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    // no write into a full queue, no read from an empty one
    assert property (@(posedge clk) disable iff (!rst_n)
        (full |-> !push) and (empty |-> !pop))
        else $error("queue overflow or underflow");

    // fill count stays within the depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ===== sv/bpg_back.sv =====
`timescale 1ns / 1ps
// back end: expands each job into glyph words, one per cycle while the output is not stalled
module bpg_back
    import bpg_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic [2:0] palette_select,
    input  job_t      head,
    input  logic      empty,
    output logic      pop,
    output logic      gly_valid,
    input  logic      gly_stall,
    output gly_word_t gly_data
);

    logic [2:0] slot_reg;
    logic       gly_valid_reg;
    gly_word_t  gly_data_reg;

    logic       load;
    logic       last_slot;
    logic [3:0] level;
    logic       pix_bit;
    gly_word_t  word;

    assign load      = !empty && (!gly_valid_reg || !gly_stall);
    assign last_slot = (({1'b0, slot_reg} + 4'd1) == head.count);
    assign pop       = load && last_slot;

    // glyph for the current pixel of the head job
    always_comb
    begin
        pix_bit         = head.data[~slot_reg];
        level           = (slot_reg == 3'd0) ? head.data[7:4] : head.data[3:0];
        word.glyph      = head.bitmap ? (pix_bit ? GLYPH_SET : GLYPH_CLEAR)
                                      : level_glyph(level, palette_select);
        word.out_row    = head.row;
        word.out_column = head.column + {9'd0, slot_reg};
        word.last       = last_slot;
        word.image_done = head.done && last_slot;
    end

    // output register and pixel slot within the job
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gly_valid_reg <= 1'b0;
            slot_reg      <= '0;
        end
        else
        begin
            if (load)
            begin
                gly_valid_reg <= 1'b1;
                slot_reg      <= last_slot ? 3'd0 : slot_reg + 3'd1;
            end
            else if (!gly_stall)
            begin
                gly_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            gly_data_reg <= word;
    end

    assign gly_valid = gly_valid_reg;
    assign gly_data  = gly_data_reg;

`ifndef ASSERT_OFF
    // image completion only on the final word of a byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (gly_valid && gly_data.image_done) |-> gly_data.last)
        else $error("image_done without last");

    // slot stays inside the head job
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (head.count != 4'd0 && {1'b0, slot_reg} < head.count))
        else $error("pixel slot beyond job count");
`endif

endmodule

// ===== sv/bmp_pixel_stream_to_glyphs.sv =====
`timescale 1ns / 1ps
// a byte's job is written into the job queue, and its glyph words into the output register
// throughput: one byte per cycle while bytes give at most one pixel and gly_stall is low;
// a byte of n pixels (up to 8 at 1bpp, 2 at 4bpp) holds the back end for n glyph words,
// set by the single glyph output register, a 4-entry job queue absorbs bursts
// reset: counters, queue and output cleared at once, registers to defaults;
// no clearing pass, the block takes bytes on the first cycle after reset
module bmp_pixel_stream_to_glyphs
    import bpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  pix_word_t             pix_data,
    output logic                  gly_valid,
    input  logic                  gly_stall,
    output gly_word_t             gly_data
);

    cfg_t cfg_reg;
    logic queue_full, queue_empty, job_push, job_pop;
    job_t push_job, head_job;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.depth_mode     <= MODE_8BPP;
            cfg_reg.image_width    <= 13'd1;
            cfg_reg.image_height   <= 13'd1;
            cfg_reg.palette_select <= 3'd0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_DEPTH:   cfg_reg.depth_mode     <= cfg_data[2:0];
                REG_WIDTH:   cfg_reg.image_width    <= cfg_data[12:0];
                REG_HEIGHT:  cfg_reg.image_height   <= cfg_data[12:0];
                REG_PALETTE: cfg_reg.palette_select <= cfg_data[2:0];
            endcase
        end
    end

    // byte intake and classification
    bpg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pix_data   (pix_data),
        .queue_full (queue_full),
        .job_push   (job_push),
        .job        (push_job)
    );

    // job queue
    bpg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (job_pop),
        .head     (head_job),
        .empty    (queue_empty)
    );

    // glyph expansion
    bpg_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .palette_select (cfg_reg.palette_select),
        .head           (head_job),
        .empty          (queue_empty),
        .pop            (job_pop),
        .gly_valid      (gly_valid),
        .gly_stall      (gly_stall),
        .gly_data       (gly_data)
    );

endmodule

// ===== tb/glyph_stream_check.sv =====
`timescale 1ns / 1ps
// glyph stream checker: predicts the glyph words of each pixel byte and compares the block's output
module glyph_stream_check
    import bpg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  pix_valid,
    input  logic                  pix_stall,
    input  pix_word_t             pix_data,
    input  logic                  gly_valid,
    input  logic                  gly_stall,
    input  gly_word_t             gly_data,
    output int                    mismatch_count,
    output int                    waiting_glyphs,
    output int                    checked_glyphs
);

    // palette choices in bits 2:1 of the palette register
    localparam logic [1:0] PAL_FINE   = 2'd0;
    localparam logic [1:0] PAL_ROUND  = 2'd1;
    localparam logic [1:0] PAL_LETTER = 2'd2;
    localparam logic [1:0] PAL_BLOCKS = 2'd3;

    // block shading codes
    localparam logic [7:0] BLANK_GLYPH = 8'd32;
    localparam logic [7:0] LIGHT_SHADE = 8'd176;
    localparam logic [7:0] DARK_SHADE  = 8'd178;
    localparam logic [7:0] FULL_BLOCK  = 8'd219;

    string ramp_fine   = " .:!/rl1Z4H9W8$@";
    string ramp_round  = " .:^uwUW";
    string ramp_letter = " .:^raAR";

    // shadow copy of the registers
    logic [2:0]  depth_sel;
    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [2:0]  palette_reg;

    // scan position of the predictor
    logic [12:0] scan_row;
    logic [12:0] pixel_col;
    logic [14:0] row_bytes;
    logic [9:0]  chan_sum;
    logic [1:0]  chan_idx;
    logic        image_complete;

    gly_word_t   expected_glyphs[$];
    gly_word_t   step_words[8];
    int          step_count;
    int          errors;
    int          checked;

    function automatic int eff_width();
        int v;
        v = width_reg;
        if (v < 1) v = 1;
        if (v > MAX_WIDTH) v = MAX_WIDTH;
        return v;
    endfunction

    function automatic int eff_height();
        int v;
        v = height_reg;
        if (v < 1) v = 1;
        if (v > MAX_HEIGHT) v = MAX_HEIGHT;
        return v;
    endfunction

    // undefined depth codes fall back to 8bpp
    function automatic logic [2:0] eff_mode();
        return (depth_sel > MODE_32BPP) ? MODE_8BPP : depth_sel;
    endfunction

    // scale a 4-bit level onto the selected palette
    function automatic logic [7:0] shade_glyph(input logic [3:0] level);
        int         len;
        int         idx;
        logic [7:0] g;
        case (palette_reg[2:1])
            PAL_FINE:   len = 16;
            PAL_BLOCKS: len = 4;
            default:    len = 8;
        endcase
        idx = (int'(level) * len) / 16;
        if (palette_reg[0]) idx = len - 1 - idx;
        case (palette_reg[2:1])
            PAL_FINE:   g = ramp_fine[idx];
            PAL_ROUND:  g = ramp_round[idx];
            PAL_LETTER: g = ramp_letter[idx];
            default:
            begin
                case (idx)
                    0:       g = BLANK_GLYPH;
                    1:       g = LIGHT_SHADE;
                    2:       g = DARK_SHADE;
                    default: g = FULL_BLOCK;
                endcase
            end
        endcase
        return g;
    endfunction

    // one pixel out at the current position
    task automatic emit_glyph(input logic [7:0] g);
        int        w;
        int        h;
        int        row;
        logic      done;
        gly_word_t word;
        w = eff_width();
        h = eff_height();
        row = (scan_row < h) ? (h - 1 - scan_row) : 0;
        done = (pixel_col + 1 >= w) && (scan_row + 1 >= h);
        word.glyph = g;
        word.out_row = row[11:0];
        word.out_column = pixel_col[11:0];
        word.last = 1'b0;
        word.image_done = done;
        step_words[step_count] = word;
        step_count++;
        pixel_col++;
        if (done) image_complete = 1'b1;
    endtask

    // expected glyph words for one accepted pixel byte
    task automatic predict_glyphs(input pix_word_t word);
        logic [7:0] b;
        logic [2:0] mode;
        int         w;
        int         h;
        int         data_bytes;
        int         stride;
        int         need;
        int         next_idx;
        int         k;
        b = word.pixel_byte;
        w = eff_width();
        h = eff_height();
        mode = eff_mode();
        step_count = 0;

        // new image clears the scan position
        if (word.frame_start)
        begin
            scan_row = '0;
            pixel_col = '0;
            row_bytes = '0;
            chan_sum = '0;
            chan_idx = '0;
            image_complete = 1'b0;
        end
        if (image_complete) return;

        case (mode)
            MODE_1BPP:  data_bytes = (w + 7) / 8;
            MODE_4BPP:  data_bytes = (w + 1) / 2;
            MODE_24BPP: data_bytes = 3 * w;
            MODE_32BPP: data_bytes = 4 * w;
            default:    data_bytes = w;
        endcase
        stride = (data_bytes + 3) & ~3;

        // pixels carried by this byte, none on row padding
        if (pixel_col < w)
        begin
            case (mode)
                MODE_1BPP:
                begin
                    for (k = 0; k < 8 && pixel_col < w; k++)
                        emit_glyph(b[7 - k] ? BLANK_GLYPH : FULL_BLOCK);
                end
                MODE_4BPP:
                begin
                    emit_glyph(shade_glyph(b[7:4]));
                    if (pixel_col < w) emit_glyph(shade_glyph(b[3:0]));
                end
                MODE_24BPP, MODE_32BPP:
                begin
                    need = (mode == MODE_24BPP) ? 3 : 4;
                    if (chan_idx < 3) chan_sum = chan_sum + b;
                    next_idx = chan_idx + 1;
                    if (next_idx >= need)
                    begin
                        emit_glyph(shade_glyph(4'((int'(chan_sum) / 3) / 16)));
                        chan_sum = '0;
                        chan_idx = '0;
                    end
                    else
                        chan_idx = next_idx[1:0];
                end
                default:
                    emit_glyph(shade_glyph(b[7:4]));
            endcase
        end

        // row accounting including padding
        if (!image_complete)
        begin
            row_bytes++;
            if (row_bytes >= stride)
            begin
                row_bytes = '0;
                pixel_col = '0;
                chan_sum = '0;
                chan_idx = '0;
                scan_row++;
                if (scan_row >= h) image_complete = 1'b1;
            end
        end

        if (step_count > 0) step_words[step_count - 1].last = 1'b1;
        for (k = 0; k < step_count; k++) expected_glyphs.push_back(step_words[k]);
    endtask

    // compare one output word against the oldest expectation
    task automatic compare_glyph(input gly_word_t got);
        gly_word_t want;
        if (expected_glyphs.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected glyph word: glyph %02h row %0d col %0d last %b done %b",
                         got.glyph, got.out_row, got.out_column, got.last, got.image_done);
            return;
        end
        want = expected_glyphs.pop_front();
        checked++;
        if (got.glyph !== want.glyph || got.out_row !== want.out_row ||
            got.out_column !== want.out_column || got.last !== want.last ||
            got.image_done !== want.image_done)
        begin
            errors++;
            if (errors <= 10)
                $display("glyph mismatch: want %02h r%0d c%0d l%b d%b, got %02h r%0d c%0d l%b d%b",
                         want.glyph, want.out_row, want.out_column, want.last, want.image_done,
                         got.glyph, got.out_row, got.out_column, got.last, got.image_done);
        end
    endtask

    // watch the configuration port and both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_sel = MODE_8BPP;
            width_reg = 13'd1;
            height_reg = 13'd1;
            palette_reg = 3'd0;
            scan_row = '0;
            pixel_col = '0;
            row_bytes = '0;
            chan_sum = '0;
            chan_idx = '0;
            image_complete = 1'b0;
            expected_glyphs.delete();
            errors = 0;
            checked = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_DEPTH:   depth_sel = cfg_data[2:0];
                    REG_WIDTH:   width_reg = cfg_data[12:0];
                    REG_HEIGHT:  height_reg = cfg_data[12:0];
                    REG_PALETTE: palette_reg = cfg_data[2:0];
                    default:     ;
                endcase
            end
            if (pix_valid && !pix_stall) predict_glyphs(pix_data);
            if (gly_valid && !gly_stall) compare_glyph(gly_data);
        end
        mismatch_count <= errors;
        waiting_glyphs <= expected_glyphs.size();
        checked_glyphs <= checked;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top: pixel byte stimulus, glyph sink stalls, register writes and verdict
module tb_top;
    import bpg_pkg::*;

    localparam int CYCLE_LIMIT   = 1500000;
    localparam int DRAIN_CYCLES  = 8;
    localparam int RANDOM_BYTES  = 380;
    localparam logic [2:0] MODE_UNDEFINED = 3'd7;

    typedef enum {
        FRAME_WHOLE,
        FRAME_TRUNCATED,
        FRAME_RESTARTED,
        FRAME_RESIZED,
        FRAME_OVERRUN
    } frame_shape_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [1:0]            cfg_index = REG_DEPTH;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    pix_word_t             pix_data = '0;
    logic                  gly_valid;
    logic                  gly_stall = 1'b0;
    gly_word_t             gly_data;

    int                    mismatch_count;
    int                    waiting_glyphs;
    int                    checked_glyphs;
    int                    cycles = 0;
    int                    stall_run = 0;
    int                    bytes_sent = 0;
    int                    frames_started = 0;
    logic                  quiet_gaps = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    bmp_pixel_stream_to_glyphs DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_data  (pix_data),
        .gly_valid (gly_valid),
        .gly_stall (gly_stall),
        .gly_data  (gly_data)
    );

    glyph_stream_check glyph_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pix_valid      (pix_valid),
        .pix_stall      (pix_stall),
        .pix_data       (pix_data),
        .gly_valid      (gly_valid),
        .gly_stall      (gly_stall),
        .gly_data       (gly_data),
        .mismatch_count (mismatch_count),
        .waiting_glyphs (waiting_glyphs),
        .checked_glyphs (checked_glyphs)
    );

    // run time guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // glyph sink: free runs, short stalls and the odd long one
    always @(posedge clk)
    begin : sink_stall
        int roll;
        if (stall_run == 0)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 5)
            begin
                gly_stall <= 1'b0;
                stall_run = $urandom_range(1, 40);
            end
            else if (roll < 9)
            begin
                gly_stall <= 1'b1;
                stall_run = $urandom_range(1, 3);
            end
            else
            begin
                gly_stall <= 1'b1;
                stall_run = $urandom_range(10, 25);
            end
        end
        stall_run = stall_run - 1;
    end

    // idle cycles before a pixel word
    function automatic int pick_gap();
        int roll;
        if (quiet_gaps) return 0;
        roll = $urandom_range(0, 9);
        if (roll < 6) return 0;
        if (roll < 9) return $urandom_range(1, 3);
        return $urandom_range(8, 20);
    endfunction

    function automatic logic [7:0] rand_pixel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // bytes per padded row for the effective depth and width
    function automatic int row_stride(input logic [2:0] mode, input int width);
        int w;
        int n;
        w = (width < 1) ? 1 : (width > MAX_WIDTH) ? MAX_WIDTH : width;
        case (mode)
            MODE_1BPP:  n = (w + 7) / 8;
            MODE_4BPP:  n = (w + 1) / 2;
            MODE_24BPP: n = 3 * w;
            MODE_32BPP: n = 4 * w;
            default:    n = w;
        endcase
        return (n + 3) & ~3;
    endfunction

    task automatic send_byte(input logic [7:0] value, input logic start);
        int        gap;
        pix_word_t word;
        gap = pick_gap();
        if (gap > 0)
        begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word.pixel_byte = value;
        word.frame_start = start;
        pix_valid <= 1'b1;
        pix_data <= word;
        do @(posedge clk); while (pix_stall);
        bytes_sent++;
        if (start) frames_started++;
    endtask

    // wait until every expected glyph has come out, then let the pipe empty
    task automatic settle();
        pix_valid <= 1'b0;
        do @(posedge clk); while (waiting_glyphs != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // one register write, caller drops the write enable
    task automatic write_reg(input cfg_reg_t idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic configure(input logic [2:0] mode, input int width, input int height,
                             input int pal);
        write_reg(REG_DEPTH, int'(mode));
        write_reg(REG_WIDTH, width);
        write_reg(REG_HEIGHT, height);
        write_reg(REG_PALETTE, pal);
        cfg_write <= 1'b0;
    endtask

    initial
    begin : stimulus
        int           random_bytes;
        int           total;
        int           cut;
        int           i;
        int           wide;
        int           tall;
        logic [2:0]   mode;
        frame_shape_t shape;
        random_bytes = 0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // register defaults, then a byte after the image is done
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        settle();

        // 1bpp ignores the palette, width not a multiple of eight
        configure(MODE_1BPP, 10, 1, 7);
        send_byte(8'hA5, 1'b1);
        send_byte(8'hC0, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        settle();

        // 4bpp odd width drops the trailing nibble, reversed palette
        configure(MODE_4BPP, 3, 1, 3);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hF7, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
        settle();

        // 24bpp full white pixel plus padding
        configure(MODE_24BPP, 1, 1, 4);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h12, 1'b0);
        settle();

        // 32bpp, fourth channel ignored, block palette
        configure(MODE_32BPP, 1, 1, 6);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        settle();

        // undefined depth code, zero width and height
        configure(MODE_UNDEFINED, 0, 0, 2);
        send_byte(8'h80, 1'b1);
        settle();

        // oversize width and height saturate, first bytes of a huge frame
        configure(MODE_1BPP, 8191, 8191, 0);
        send_byte(8'h0F, 1'b1);
        send_byte(8'hF0, 1'b0);
        settle();

        // shrink width, then height, in the middle of a frame
        configure(MODE_8BPP, 4, 2, 1);
        send_byte(8'h10, 1'b1);
        send_byte(8'h90, 1'b0);
        settle();
        write_reg(REG_WIDTH, 1);
        cfg_write <= 1'b0;
        send_byte(8'h20, 1'b0);
        send_byte(8'h30, 1'b0);
        settle();
        write_reg(REG_HEIGHT, 1);
        cfg_write <= 1'b0;
        send_byte(8'hE0, 1'b0);
        settle();

        // random frames, mostly well formed
        while (random_bytes < RANDOM_BYTES)
        begin
            mode = 3'($urandom_range(0, 7));
            wide = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 24);
            if (mode == MODE_24BPP || mode == MODE_32BPP) wide = $urandom_range(1, 8);
            tall = $urandom_range(1, 4);
            settle();
            configure(mode, wide, tall, $urandom_range(0, 7));
            quiet_gaps = ($urandom_range(0, 3) == 0);
            total = row_stride(mode, wide) * tall;
            cut = $urandom_range(1, total);
            case ($urandom_range(0, 9))
                5:       shape = FRAME_TRUNCATED;
                6:       shape = FRAME_RESTARTED;
                7:       shape = FRAME_RESIZED;
                8:       shape = FRAME_OVERRUN;
                default: shape = FRAME_WHOLE;
            endcase

            // abandoned prefix before a fresh start
            if (shape == FRAME_RESTARTED)
            begin
                for (i = 0; i < cut; i++)
                begin
                    send_byte(rand_pixel(), i == 0);
                    random_bytes++;
                end
            end

            for (i = 0; i < total; i++)
            begin
                if (shape == FRAME_TRUNCATED && i == cut) break;
                if (shape == FRAME_RESIZED && i == cut)
                begin
                    settle();
                    if ($urandom_range(0, 1))
                        write_reg(REG_WIDTH, $urandom_range(1, 12));
                    else
                        write_reg(REG_HEIGHT, $urandom_range(1, 4));
                    cfg_write <= 1'b0;
                end
                send_byte(rand_pixel(), i == 0);
                random_bytes++;
            end

            // trailing bytes after the image are dropped by the block
            if (shape == FRAME_OVERRUN)
                repeat ($urandom_range(1, 6)) send_byte(rand_pixel(), 1'b0);
        end

        quiet_gaps = 1'b0;
        settle();

        $display("sent %0d pixel words in %0d frames, %0d glyph words checked",
                 bytes_sent, frames_started, checked_glyphs);
        $display("all depths incl. undefined code, every palette, size extremes, mid-frame resize");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
